[hdl/tsme_pkg.sv]
// Shared types and constants of the two-set membership engine.
`default_nettype none
package tsme_pkg;

   localparam int ELEM_W = 32;
   localparam int SIZE_W = 5;

   // Operation codes of an input item.
   localparam logic [2:0] OP_ADD      = 3'd0;
   localparam logic [2:0] OP_REMOVE   = 3'd1;
   localparam logic [2:0] OP_CONTAINS = 3'd2;
   localparam logic [2:0] OP_UNION    = 3'd3;
   localparam logic [2:0] OP_INTERSEC = 3'd4;
   localparam logic [2:0] OP_DIFF     = 3'd5;
   localparam logic [2:0] OP_SUBSET   = 3'd6;

   // Status codes of a result item.
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NO_CHANGE = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   // One result item handed from the sequencer to the output register.
   typedef struct packed {
      logic                     push;
      logic signed [ELEM_W-1:0] element_out;
      logic                     element_valid;
      logic                     answer_flag;
      logic [1:0]               status;
      logic [SIZE_W-1:0]        set_size;
      logic                     last;
   } rsp_push_type;

endpackage
`default_nettype wire

[hdl/tsme_req_if.sv]
// Request channel interface: operation items into the engine.
`default_nettype none
interface tsme_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        operation;
   logic              set_select;
   logic signed [31:0] element;

   modport source (output valid, output operation, output set_select, output element,
                   input ready);
   modport sink   (input valid, input operation, input set_select, input element,
                   output ready);
endinterface
`default_nettype wire

[hdl/tsme_rsp_if.sv]
// Response channel interface: result items out of the engine.
`default_nettype none
interface tsme_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] element_out;
   logic               element_valid;
   logic               answer_flag;
   logic [1:0]         status;
   logic [4:0]         set_size;
   logic               last;

   modport source (output valid, output element_out, output element_valid,
                   output answer_flag, output status, output set_size, output last,
                   input ready);
   modport sink   (input valid, input element_out, input element_valid,
                   input answer_flag, input status, input set_size, input last,
                   output ready);
endinterface
`default_nettype wire

[hdl/tsme_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tsme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/tsme_seq.sv]
// Sequencer, set stores and shared compare unit of the membership engine.
`default_nettype none
module tsme_seq #(
   parameter int SET_CAPACITY = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   tsme_req_if.sink             req,
   output tsme_pkg::rsp_push_type push,
   input  wire logic            push_free
);

   localparam int ElemW  = tsme_pkg::ELEM_W;
   localparam int SizeW  = tsme_pkg::SIZE_W;
   localparam int AddrW  = $clog2(SET_CAPACITY);
   localparam int CntW   = $clog2(SET_CAPACITY + 1);
   localparam logic [CntW-1:0] CapCnt = CntW'(SET_CAPACITY);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_SRCH_RD  = 11'b000_0000_0010,
      ST_SRCH_CMP = 11'b000_0000_0100,
      ST_RESOLVE  = 11'b000_0000_1000,
      ST_OUTER_RD = 11'b000_0001_0000,
      ST_OUTER_CAP= 11'b000_0010_0000,
      ST_KEEP     = 11'b000_0100_0000,
      ST_SHIFT_RD = 11'b000_1000_0000,
      ST_SHIFT_WR = 11'b001_0000_0000,
      ST_FINISH   = 11'b010_0000_0000,
      ST_DONE     = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic              sel_ff, sel_in;
   logic [ElemW-1:0]  key_ff, key_in;
   logic              pass_ff, pass_in;
   logic [CntW-1:0]   i_ff, i_in;
   logic [CntW-1:0]   j_ff, j_in;
   logic              hit_ff, hit_in;
   logic              flag_ff, flag_in;
   logic [1:0]        status_ff, status_in;
   logic              srch_ff, srch_in;
   logic [ElemW-1:0]  pend_ff, pend_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [CntW-1:0]   cnt0_ff, cnt0_in;
   logic [CntW-1:0]   cnt1_ff, cnt1_in;
   logic              rd_sel_ff, rd_sel_in;

   logic              wr_en;
   logic              wr_set;
   logic [AddrW-1:0]  wr_addr;
   logic [ElemW-1:0]  wr_data;
   logic [AddrW-1:0]  rd_addr;
   logic [ElemW-1:0]  q0, q1, rd_data;
   logic [CntW-1:0]   cnt_sel, cnt_outer, cnt_srch, cnt_sel_in, jm1;
   logic              outer_set, eq, keep;

   tsme_ram #(.WIDTH(ElemW), .DEPTH(SET_CAPACITY)) u_ram0 (
      .clock   (clock),
      .wr_en   (wr_en && !wr_set),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (q0)
   );

   tsme_ram #(.WIDTH(ElemW), .DEPTH(SET_CAPACITY)) u_ram1 (
      .clock   (clock),
      .wr_en   (wr_en && wr_set),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (q1)
   );

   assign outer_set = sel_ff ^ pass_ff;
   assign cnt_sel   = sel_ff    ? cnt1_ff : cnt0_ff;
   assign cnt_outer = outer_set ? cnt1_ff : cnt0_ff;
   assign cnt_srch  = srch_ff   ? cnt1_ff : cnt0_ff;
   assign rd_data   = rd_sel_ff ? q1 : q0;
   assign eq        = (rd_data == key_ff);
   assign jm1       = j_ff - 1'b1;

   // Intersection keeps hits; difference and the second union pass keep misses.
   assign keep = (op_ff == tsme_pkg::OP_INTERSEC) ? hit_ff : !hit_ff;

   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      sel_in      = sel_ff;
      key_in      = key_ff;
      pass_in     = pass_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      hit_in      = hit_ff;
      flag_in     = flag_ff;
      status_in   = status_ff;
      srch_in     = srch_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      cnt_sel_in  = cnt_sel;
      wr_en       = 1'b0;
      wr_set      = sel_ff;
      wr_addr     = j_ff[AddrW-1:0];
      wr_data     = key_ff;
      push        = '0;

      if (state_ff == ST_OUTER_RD) begin
         rd_addr   = i_ff[AddrW-1:0];
         rd_sel_in = outer_set;
      end else if (state_ff == ST_SHIFT_RD) begin
         rd_addr   = j_ff[AddrW-1:0];
         rd_sel_in = sel_ff;
      end else begin
         rd_addr   = j_ff[AddrW-1:0];
         rd_sel_in = srch_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in       = req.operation;
               sel_in      = req.set_select;
               srch_in     = req.set_select;
               key_in      = req.element;
               status_in   = tsme_pkg::ST_DONE;
               flag_in     = (req.operation == tsme_pkg::OP_SUBSET);
               hit_in      = 1'b0;
               pass_in     = 1'b0;
               i_in        = '0;
               j_in        = '0;
               pend_vld_in = 1'b0;
               case (req.operation)
                  tsme_pkg::OP_ADD,
                  tsme_pkg::OP_REMOVE,
                  tsme_pkg::OP_CONTAINS: state_in = ST_SRCH_RD;
                  tsme_pkg::OP_UNION,
                  tsme_pkg::OP_INTERSEC,
                  tsme_pkg::OP_DIFF,
                  tsme_pkg::OP_SUBSET:   state_in = ST_OUTER_RD;
                  default: begin
                     status_in = tsme_pkg::ST_NO_CHANGE;
                     state_in  = ST_DONE;
                  end
               endcase
            end
         end
         ST_SRCH_RD: begin
            if (j_ff >= cnt_srch) begin
               hit_in   = 1'b0;
               state_in = ST_RESOLVE;
            end else begin
               state_in = ST_SRCH_CMP;
            end
         end
         ST_SRCH_CMP: begin
            if (eq) begin
               hit_in   = 1'b1;
               state_in = ST_RESOLVE;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_SRCH_RD;
            end
         end
         ST_RESOLVE: begin
            case (op_ff)
               tsme_pkg::OP_ADD: begin
                  state_in = ST_DONE;
                  if (hit_ff) begin
                     status_in = tsme_pkg::ST_NO_CHANGE;
                  end else if (cnt_sel >= CapCnt) begin
                     status_in = tsme_pkg::ST_FULL;
                  end else begin
                     wr_en      = 1'b1;
                     wr_addr    = cnt_sel[AddrW-1:0];
                     cnt_sel_in = cnt_sel + 1'b1;
                  end
               end
               tsme_pkg::OP_REMOVE: begin
                  if (hit_ff) begin
                     j_in     = j_ff + 1'b1;
                     state_in = ST_SHIFT_RD;
                  end else begin
                     status_in = tsme_pkg::ST_NO_CHANGE;
                     state_in  = ST_DONE;
                  end
               end
               tsme_pkg::OP_CONTAINS: begin
                  flag_in  = hit_ff;
                  state_in = ST_DONE;
               end
               tsme_pkg::OP_SUBSET: begin
                  if (hit_ff) begin
                     i_in     = i_ff + 1'b1;
                     state_in = ST_OUTER_RD;
                  end else begin
                     flag_in  = 1'b0;
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  if (keep) begin
                     state_in = ST_KEEP;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = ST_OUTER_RD;
                  end
               end
            endcase
         end
         ST_OUTER_RD: begin
            if (i_ff >= cnt_outer) begin
               if (op_ff == tsme_pkg::OP_SUBSET) begin
                  state_in = ST_DONE;
               end else if (op_ff == tsme_pkg::OP_UNION && !pass_ff) begin
                  pass_in = 1'b1;
                  i_in    = '0;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               state_in = ST_OUTER_CAP;
            end
         end
         ST_OUTER_CAP: begin
            key_in = rd_data;
            if (op_ff == tsme_pkg::OP_UNION && !pass_ff) begin
               state_in = ST_KEEP;
            end else begin
               srch_in  = !outer_set;
               j_in     = '0;
               state_in = ST_SRCH_RD;
            end
         end
         ST_KEEP: begin
            // The newest kept element waits in the pending register so that
            // the final one can carry the last mark.
            if (!pend_vld_ff) begin
               pend_in     = key_ff;
               pend_vld_in = 1'b1;
               i_in        = i_ff + 1'b1;
               state_in    = ST_OUTER_RD;
            end else if (push_free) begin
               push.push          = 1'b1;
               push.element_out   = pend_ff;
               push.element_valid = 1'b1;
               push.set_size      = SizeW'(cnt_sel);
               pend_in            = key_ff;
               i_in               = i_ff + 1'b1;
               state_in           = ST_OUTER_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (j_ff >= cnt_sel) begin
               cnt_sel_in = cnt_sel - 1'b1;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = jm1[AddrW-1:0];
            wr_data  = rd_data;
            j_in     = j_ff + 1'b1;
            state_in = ST_SHIFT_RD;
         end
         ST_FINISH: begin
            if (push_free) begin
               push.push          = 1'b1;
               push.element_out   = pend_vld_ff ? pend_ff : '0;
               push.element_valid = pend_vld_ff;
               push.set_size      = SizeW'(cnt_sel);
               push.last          = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (push_free) begin
               push.push        = 1'b1;
               push.answer_flag = flag_ff;
               push.status      = status_ff;
               push.set_size    = SizeW'(cnt_sel);
               push.last        = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      cnt0_in = sel_ff ? cnt0_ff : cnt_sel_in;
      cnt1_in = sel_ff ? cnt_sel_in : cnt1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt0_ff     <= '0;
         cnt1_ff     <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt0_ff     <= cnt0_in;
         cnt1_ff     <= cnt1_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      sel_ff    <= sel_in;
      key_ff    <= key_in;
      pass_ff   <= pass_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      hit_ff    <= hit_in;
      flag_ff   <= flag_in;
      status_ff <= status_in;
      srch_ff   <= srch_in;
      pend_ff   <= pend_in;
      rd_sel_ff <= rd_sel_in;
   end

endmodule
`default_nettype wire

[hdl/tsme_out_stage.sv]
// Output register that holds one result item until the receiver takes it.
`default_nettype none
module tsme_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tsme_pkg::rsp_push_type push,
   output logic                   push_free,
   tsme_rsp_if.source             rsp
);

   logic                   full_ff, full_in;
   tsme_pkg::rsp_push_type data_ff, data_in;

   assign push_free = !full_ff || rsp.ready;

   always_comb begin
      full_in = full_ff;
      data_in = data_ff;
      if (push.push) begin
         full_in = 1'b1;
         data_in = push;
      end else if (rsp.ready) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp.valid         = full_ff;
   assign rsp.element_out   = data_ff.element_out;
   assign rsp.element_valid = data_ff.element_valid;
   assign rsp.answer_flag   = data_ff.answer_flag;
   assign rsp.status        = data_ff.status;
   assign rsp.set_size      = data_ff.set_size;
   assign rsp.last          = data_ff.last;

endmodule
`default_nettype wire

[hdl/two_set_membership_engine.sv]
// Top level of the two-set membership engine: sequencer and output register.
//
// The engine keeps two sets of distinct signed 32-bit values in insertion order.
// Each request item on req_ch names an operation (add, remove, contains, union,
// intersection, difference, subset) and a selected set; the other set is the
// right-hand operand. Every request gives one or more result items on rsp_ch,
// and the final one carries last.
// One request is worked at a time: req_ch.ready is high only while the
// sequencer is idle. A single 32-bit equality compare and one read port per
// set store are reused step by step, with a read and then a compare for every
// stored entry that is visited. Add, remove and contains search the selected
// set; subset, intersection and difference search the other set for each entry
// of the selected set; union adds a second walk over the other set, checked
// against the selected set. Reset clears both counts, so both sets read as
// empty; the stores themselves need no clearing. The result register lets the
// next request be taken while the last result waits; if the receiver stalls,
// the sequencer stops at its next result and waits, losing nothing.
`default_nettype none
module two_set_membership_engine #(
   parameter int SET_CAPACITY = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tsme_req_if.sink   req_ch,
   tsme_rsp_if.source rsp_ch
);

   // Result items travel from the sequencer to the output register as a struct.
   tsme_pkg::rsp_push_type push;
   logic                   push_free;

   tsme_seq #(.SET_CAPACITY(SET_CAPACITY)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .push      (push),
      .push_free (push_free)
   );

   tsme_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_free (push_free),
      .rsp       (rsp_ch)
   );

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the two-set membership engine.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Capacity of each set; the engine is built with the same value.
   localparam int CAPACITY = 16;

   // The engine has no name for the eighth operation code; it must act as a no-op.
   localparam logic [2:0] OP_UNUSED = 3'd7;

   localparam int POOL_N = 24;

   // One result item as seen on the response channel.
   typedef struct packed {
      logic signed [tsme_pkg::ELEM_W-1:0] element_out;
      logic                               element_valid;
      logic                               answer_flag;
      logic [1:0]                         status;
      logic [tsme_pkg::SIZE_W-1:0]        set_size;
      logic                               last;
   } set_result_type;

   // The scoreboard mirrors both sets, predicts the result items of every
   // accepted request and checks the response stream against them in order.
   class set_pair_scoreboard_type;
      logic signed [tsme_pkg::ELEM_W-1:0] store [2][CAPACITY];
      int unsigned                        count [2];
      set_result_type                     expected_results [$];
      int unsigned                        errors;
      int unsigned                        results_seen;
      int unsigned                        dropped_adds;
      int unsigned                        empty_answers;
      int unsigned                        ops_seen [8];

      // Only entries below the count are ever looked at.
      function bit holds(input int unsigned s,
                         input logic signed [tsme_pkg::ELEM_W-1:0] v);
         for (int unsigned i = 0; i < count[s]; i++)
            if (store[s][i] == v)
               return 1'b1;
         return 1'b0;
      endfunction

      function void queue_result(input logic signed [tsme_pkg::ELEM_W-1:0] elem,
                                 input logic valid, input logic flag,
                                 input logic [1:0] status,
                                 input int unsigned size, input logic last);
         set_result_type r;
         r.element_out   = elem;
         r.element_valid = valid;
         r.answer_flag   = flag;
         r.status        = status;
         r.set_size      = tsme_pkg::SIZE_W'(size);
         r.last          = last;
         expected_results = {expected_results, r};
      endfunction

      // Applies one accepted request to the mirrored sets and queues its results.
      function void note_request(input logic [2:0] op, input logic sel,
                                 input logic signed [tsme_pkg::ELEM_W-1:0] value);
         int unsigned s;
         int unsigned oth;
         int unsigned first_new;
         logic [1:0]  status;
         logic        flag;
         bit          keep;
         s         = sel ? 1 : 0;
         oth       = sel ? 0 : 1;
         status    = tsme_pkg::ST_DONE;
         flag      = 1'b0;
         first_new = expected_results.size();
         ops_seen[op]++;
         case (op)
            tsme_pkg::OP_ADD: begin
               if (holds(s, value)) begin
                  status = tsme_pkg::ST_NO_CHANGE;
               end else if (count[s] >= CAPACITY) begin
                  status = tsme_pkg::ST_FULL;
                  dropped_adds++;
               end else begin
                  store[s][count[s]] = value;
                  count[s]++;
               end
            end
            tsme_pkg::OP_REMOVE: begin
               status = tsme_pkg::ST_NO_CHANGE;
               for (int unsigned i = 0; i < count[s]; i++) begin
                  if (store[s][i] == value) begin
                     // Later entries move down one place to keep insertion order.
                     for (int unsigned j = i + 1; j < count[s]; j++)
                        store[s][j-1] = store[s][j];
                     count[s]--;
                     status = tsme_pkg::ST_DONE;
                     break;
                  end
               end
            end
            tsme_pkg::OP_CONTAINS: begin
               flag = holds(s, value);
            end
            tsme_pkg::OP_UNION, tsme_pkg::OP_INTERSEC, tsme_pkg::OP_DIFF: begin
               for (int unsigned i = 0; i < count[s]; i++) begin
                  if (op == tsme_pkg::OP_UNION)
                     keep = 1'b1;
                  else if (op == tsme_pkg::OP_INTERSEC)
                     keep = holds(oth, store[s][i]);
                  else
                     keep = !holds(oth, store[s][i]);
                  if (keep)
                     queue_result(store[s][i], 1'b1, 1'b0, tsme_pkg::ST_DONE,
                                  count[s], 1'b0);
               end
               // A union goes on with the other set's values that the selected set lacks.
               if (op == tsme_pkg::OP_UNION) begin
                  for (int unsigned i = 0; i < count[oth]; i++)
                     if (!holds(s, store[oth][i]))
                        queue_result(store[oth][i], 1'b1, 1'b0, tsme_pkg::ST_DONE,
                                     count[s], 1'b0);
               end
               if (expected_results.size() == first_new) begin
                  empty_answers++;
                  queue_result('0, 1'b0, 1'b0, tsme_pkg::ST_DONE, count[s], 1'b1);
               end else begin
                  expected_results[$].last = 1'b1;
               end
               return;
            end
            tsme_pkg::OP_SUBSET: begin
               flag = 1'b1;
               for (int unsigned i = 0; i < count[s]; i++) begin
                  if (!holds(oth, store[s][i])) begin
                     flag = 1'b0;
                     break;
                  end
               end
            end
            default: begin
               status = tsme_pkg::ST_NO_CHANGE;
            end
         endcase
         queue_result('0, 1'b0, flag, status, count[s], 1'b1);
      endfunction

      task report_mismatch(input string what);
         errors++;
         $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, what);
      endtask

      task check_result(input set_result_type got);
         set_result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("result item arrived with nothing expected");
            return;
         end
         want = expected_results.pop_front();
         if (got.element_out !== want.element_out)
            report_mismatch($sformatf("element_out %0d, expected %0d",
                                      got.element_out, want.element_out));
         if (got.element_valid !== want.element_valid)
            report_mismatch($sformatf("element_valid %b, expected %b",
                                      got.element_valid, want.element_valid));
         if (got.answer_flag !== want.answer_flag)
            report_mismatch($sformatf("answer_flag %b, expected %b",
                                      got.answer_flag, want.answer_flag));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.set_size !== want.set_size)
            report_mismatch($sformatf("set_size %0d, expected %0d",
                                      got.set_size, want.set_size));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
         results_seen++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   tsme_req_if req_ch ();
   tsme_rsp_if rsp_ch ();

   two_set_membership_engine #(
      .SET_CAPACITY(CAPACITY)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   set_pair_scoreboard_type            board;
   int unsigned                        send_idle_pct;
   int unsigned                        recv_idle_pct;
   int unsigned                        items_sent;
   logic signed [tsme_pkg::ELEM_W-1:0] value_pool [POOL_N];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side. Valid and ready are sampled as they stood just before the
   // edge, so an item counts as taken exactly when the engine sees it taken.
   // Ready is then redrawn for the next cycle from the current stall rate.
   always @(posedge clock) begin
      set_result_type got;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.element_out   = rsp_ch.element_out;
         got.element_valid = rsp_ch.element_valid;
         got.answer_flag   = rsp_ch.answer_flag;
         got.status        = rsp_ch.status;
         got.set_size      = rsp_ch.set_size;
         got.last          = rsp_ch.last;
         board.check_result(got);
      end
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Offers one request and returns at the edge where it is taken. Valid stays
   // high across back-to-back items, so it only drops when a gap is inserted.
   task automatic send_item(input logic [2:0] op, input logic sel,
                            input logic signed [tsme_pkg::ELEM_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(5, 1)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.set_select <= sel;
      req_ch.element    <= value;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
      board.note_request(op, sel, value);
      items_sent++;
   endtask

   // Holds the request side quiet until every predicted result has been seen.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (board.expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Values mostly come from a small shared pool so that the two sets overlap
   // and adds, removes and lookups hit often; the rest span the full range.
   function automatic logic signed [tsme_pkg::ELEM_W-1:0] pick_value();
      if ($urandom_range(99) < 75)
         return value_pool[$urandom_range(POOL_N - 1)];
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_operation();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 35) return tsme_pkg::OP_ADD;
      if (roll < 50) return tsme_pkg::OP_REMOVE;
      if (roll < 60) return tsme_pkg::OP_CONTAINS;
      if (roll < 68) return tsme_pkg::OP_UNION;
      if (roll < 76) return tsme_pkg::OP_INTERSEC;
      if (roll < 84) return tsme_pkg::OP_DIFF;
      if (roll < 96) return tsme_pkg::OP_SUBSET;
      return OP_UNUSED;
   endfunction

   // Random traffic. Besides single random requests, some stretches fill one
   // set to capacity and push one more add at it, and others drain a set by
   // removing its members in random order, so that full and empty sets and
   // the algebra walks over them come up again and again.
   task automatic random_items(input int unsigned quota);
      int unsigned stop_at;
      int unsigned roll;
      logic        sel;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         roll = $urandom_range(99);
         sel  = $urandom_range(1);
         if (roll < 6) begin
            while (board.count[sel] < CAPACITY)
               send_item(tsme_pkg::OP_ADD, sel, pick_value());
            send_item(tsme_pkg::OP_ADD, sel, pick_value());
         end else if (roll < 11) begin
            while (board.count[sel] != 0)
               send_item(tsme_pkg::OP_REMOVE, sel,
                         board.store[sel][$urandom_range(board.count[sel] - 1)]);
         end else begin
            send_item(pick_operation(), sel, pick_value());
         end
      end
   endtask

   // Run limit: far beyond the slowest correct run, where every request is a
   // walk over two full sets and every result waits out the receiver's stalls.
   initial begin
      #10_000_000;
      $display("two_set_membership_engine verification failed");
      $finish;
   end

   initial begin
      board              = new();
      items_sent         = 0;
      send_idle_pct      = 22;
      recv_idle_pct      = 70;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= tsme_pkg::OP_ADD;
      req_ch.set_select <= 1'b0;
      req_ch.element    <= '0;

      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7FFF_FFFF;
      value_pool[2] = '0;
      value_pool[3] = -32'sd1;
      value_pool[4] = 32'sd1;
      for (int i = 5; i < POOL_N; i++)
         value_pool[i] = $urandom;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Both sets start empty: subset of an empty set holds,
      // an algebra result over empty sets is a single item with no element,
      // and lookups and removes find nothing.
      send_item(tsme_pkg::OP_SUBSET,   1'b0, $urandom);
      send_item(tsme_pkg::OP_UNION,    1'b0, $urandom);
      send_item(tsme_pkg::OP_CONTAINS, 1'b1, 32'sh7FFF_FFFF);
      send_item(tsme_pkg::OP_REMOVE,   1'b0, '0);
      // Put the extremes of the value range, zero and minus one into set 0, then repeat one.
      send_item(tsme_pkg::OP_ADD,      1'b0, 32'sh8000_0000);
      send_item(tsme_pkg::OP_ADD,      1'b0, 32'sh7FFF_FFFF);
      send_item(tsme_pkg::OP_ADD,      1'b0, '0);
      send_item(tsme_pkg::OP_ADD,      1'b0, -32'sd1);
      send_item(tsme_pkg::OP_ADD,      1'b0, 32'sh7FFF_FFFF);
      // Set 1 shares two values with set 0 and holds one of its own.
      send_item(tsme_pkg::OP_ADD,      1'b1, -32'sd1);
      send_item(tsme_pkg::OP_ADD,      1'b1, '0);
      send_item(tsme_pkg::OP_ADD,      1'b1, 32'sh5A5A_A5A5);
      send_item(tsme_pkg::OP_CONTAINS, 1'b0, 32'sh8000_0000);
      send_item(tsme_pkg::OP_CONTAINS, 1'b1, 32'sd1);
      // Algebra in both directions, including union order across the sets.
      send_item(tsme_pkg::OP_UNION,    1'b0, $urandom);
      send_item(tsme_pkg::OP_UNION,    1'b1, $urandom);
      send_item(tsme_pkg::OP_INTERSEC, 1'b0, $urandom);
      send_item(tsme_pkg::OP_DIFF,     1'b0, $urandom);
      send_item(tsme_pkg::OP_DIFF,     1'b1, $urandom);
      send_item(tsme_pkg::OP_SUBSET,   1'b0, $urandom);
      // Once its own value is gone, set 1 is a proper subset of set 0.
      send_item(tsme_pkg::OP_REMOVE,   1'b1, 32'sh5A5A_A5A5);
      send_item(tsme_pkg::OP_SUBSET,   1'b1, $urandom);
      send_item(tsme_pkg::OP_DIFF,     1'b1, $urandom);
      // Removing the first entry shifts the rest of set 0 down.
      send_item(tsme_pkg::OP_REMOVE,   1'b0, 32'sh8000_0000);
      send_item(OP_UNUSED,             1'b1, 32'sh7FFF_FFFF);

      random_items(25);

      // Each change of idling pattern starts from a fully drained engine.
      wait_drained();
      send_idle_pct = 70;
      recv_idle_pct = 22;
      random_items(25);

      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_items(25);

      // Every request gives at least one result, so once the queue is empty
      // the engine is idle; a short quiet spell catches any stray result.
      wait_drained();
      repeat (50) @(posedge clock);

      $display("Covered %0d requests: %0d adds (%0d dropped on a full set), %0d removes,",
               items_sent, board.ops_seen[tsme_pkg::OP_ADD], board.dropped_adds,
               board.ops_seen[tsme_pkg::OP_REMOVE]);
      $display("%0d lookups, %0d subsets, %0d algebra (%0d empty), %0d no-ops, %0d results.",
               board.ops_seen[tsme_pkg::OP_CONTAINS], board.ops_seen[tsme_pkg::OP_SUBSET],
               board.ops_seen[tsme_pkg::OP_UNION] + board.ops_seen[tsme_pkg::OP_INTERSEC]
                  + board.ops_seen[tsme_pkg::OP_DIFF],
               board.empty_answers, board.ops_seen[OP_UNUSED], board.results_seen);

      if (board.errors == 0 && board.expected_results.size() == 0) begin
         $display("two_set_membership_engine verification clean");
      end else begin
         $display("two_set_membership_engine verification failed");
      end
      $finish;
   end
endmodule

[filelist.f]
hdl/tsme_pkg.sv
hdl/tsme_req_if.sv
hdl/tsme_rsp_if.sv
hdl/tsme_ram.sv
hdl/tsme_seq.sv
hdl/tsme_out_stage.sv
hdl/two_set_membership_engine.sv
tb/sv/tb.sv
